### rtl/cylinder_basis_transform_unit_macros.svh
// assertion macros used by the checker file of the cylinder basis transform unit
`ifndef CYLINDER_BASIS_TRANSFORM_UNIT_MACROS_SVH
`define CYLINDER_BASIS_TRANSFORM_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define CBT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CBT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// implication that also holds through reset
`define CBT_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/cbt_pkg.sv
// shared constants and types of the cylinder basis transform unit
package cbt_pkg;

    localparam int COORD_W     = 32;
    localparam int NEAR_DIST_W = 31;
    localparam int NZL_W       = 17;
    localparam int APB_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 4;

    localparam int S_TDATA_W   = 7 * COORD_W;
    localparam int M_TDATA_W   = 320;
    localparam int M_TUSER_W   = 2;
    // side_a, axis and side_b fields together
    localparam int VEC_FIELDS_W = 9 * COORD_W;

    localparam int TUSER_CAPS  = 0;
    localparam int TUSER_DEGEN = 1;

    localparam logic [NZL_W-1:0] NZL_RESET = 17'd1;

    typedef enum logic [1:0] {
        CFG_CAMERA_X = 2'd0,
        CFG_CAMERA_Y = 2'd1,
        CFG_CAMERA_Z = 2'd2,
        CFG_NEAR_ZERO = 2'd3
    } cfg_index_t;

endpackage

### rtl/cbt_isqrt.sv
// pipelined integer square root, one result bit per stage
module cbt_isqrt #(
    parameter int IN_W = 66
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [IN_W-1:0]   radicand,
    output logic [IN_W/2-1:0] root
);
    localparam int STEPS  = IN_W / 2;
    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [IN_W-1:0]   rad_reg  [STEPS];
    logic [REM_W-1:0]  rem_reg  [STEPS];
    logic [ROOT_W-1:0] root_reg [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_step
            logic [IN_W-1:0]   rad_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic [IN_W-1:0]   rad_next;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;

            if (k == 0) begin : g_first
                assign rad_in  = radicand;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_rest
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            always_comb begin
                rem_sh   = {rem_in[REM_W-3:0], rad_in[IN_W-1 -: 2]};
                trial    = {root_in, 2'b01};
                rad_next = rad_in << 2;
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_in[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k]  <= rad_next;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[STEPS-1];

endmodule

### rtl/cbt_udiv.sv
// pipelined restoring divider, one quotient bit per stage
module cbt_udiv #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33,
    parameter int QUO_W = 17
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);
    localparam int EXT_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_step
            localparam int BIT = QUO_W - 1 - k;
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [QUO_W-1:0] quo_in;
            logic [EXT_W-1:0] rem_ext;
            logic [EXT_W-1:0] den_sh;
            logic [NUM_W-1:0] rem_next;
            logic [QUO_W-1:0] quo_next;

            if (k == 0) begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end else begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            always_comb begin
                rem_ext = EXT_W'(rem_in);
                den_sh  = EXT_W'(den_in) << BIT;
                if (rem_ext >= den_sh) begin
                    rem_next = NUM_W'(rem_ext - den_sh);
                    quo_next = quo_in | (QUO_W'(1) << BIT);
                end else begin
                    rem_next = rem_in;
                    quo_next = quo_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                    quo_reg[k] <= quo_next;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QUO_W-1];

endmodule

### rtl/cbt_delay.sv
// enabled shift line that keeps side data in step with the pipeline
module cbt_delay #(
    parameter int W     = 32,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

### rtl/cylinder_basis_transform_unit.sv
// top level of the cylinder basis transform unit
//
//  port group   direction  carries
//  s_ stream    in         start x/y/z, end x/y/z, radius
//  m_ stream    out        side_a, axis, side_b, near distance; tuser caps and degenerate
//  apb          in/out     camera x/y/z, near zero limit
//
// takes one transfer per cycle while the output buffer has room; the pipe depth
// is set by the bit-per-stage square root and divider chains
// all stages move together; a two-entry output buffer keeps input flowing while
// one result waits, and the pipe holds only when both entries are taken
// reset clears valid bits, the buffer count and the camera registers, and sets the near zero limit to 1
module cylinder_basis_transform_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // start_x, start_y, start_z, end_x, end_y, end_z, radius
    input  logic [cbt_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // side_a_x/y/z, axis_x/y/z, side_b_x/y/z, near_distance, zero pad
    output logic [cbt_pkg::M_TDATA_W-1:0]       m_tdata,
    // caps_enabled, degenerate
    output logic [cbt_pkg::M_TUSER_W-1:0]       m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbt_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [cbt_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cbt_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    localparam int F       = FRAC_BITS;
    localparam int CW      = cbt_pkg::COORD_W;
    localparam int DIFF_W  = CW + 1;
    localparam int MAG_W   = CW + 1;
    localparam int SUM1_W  = 2 * MAG_W;
    localparam int LEN_W   = SUM1_W / 2;
    localparam int Q_W     = F + 1;
    localparam int NUM1_W  = MAG_W + F;
    localparam int U_W     = F + 2;
    localparam int CMAG_W  = F + 1;
    localparam int CSUM_W  = 2 * CMAG_W;
    localparam int CLEN_W  = CSUM_W / 2;
    localparam int NUM2_W  = CMAG_W + F;
    localparam int A_W     = F + 2;
    localparam int UA_W    = 2 * A_W;
    localparam int BD_W    = UA_W + 1;
    localparam int B_W     = F + 3;
    localparam int P_W     = F + 36;
    localparam int CMP_W   = Q_W + cbt_pkg::NZL_W;
    localparam int ND_W    = cbt_pkg::NEAR_DIST_W;
    localparam int OUT_W   = cbt_pkg::M_TDATA_W + cbt_pkg::M_TUSER_W;

    // stage at which each value sits in its register
    localparam int S_L  = 3 + SUM1_W / 2;
    localparam int S_Q  = S_L + Q_W;
    localparam int S_U  = S_Q + 1;
    localparam int S_CL = S_U + 2 + CSUM_W / 2;
    localparam int S_A0 = S_CL + Q_W;
    localparam int S_A  = S_A0 + 1;
    localparam int S_B  = S_A + 2;
    localparam int S_P  = S_B + 1;

    function automatic logic [CW-1:0] sat_scale(input logic signed [P_W-1:0] v);
        logic [P_W-1:0] m;
        logic [P_W-1:0] s;
        logic [CW-1:0]  r;
        m = v[P_W-1] ? P_W'(-v) : P_W'(v);
        s = m >> F;
        if (!v[P_W-1]) begin
            r = (s > P_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : s[CW-1:0];
        end else begin
            r = (s > P_W'(33'h0_8000_0000)) ? 32'h8000_0000 : (~s[CW-1:0] + 32'd1);
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic signed [CW-1:0]      cam_reg [3];
    logic [cbt_pkg::NZL_W-1:0] nzl_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_reg[0] <= '0;
            cam_reg[1] <= '0;
            cam_reg[2] <= '0;
            nzl_reg    <= cbt_pkg::NZL_RESET;
        end else if (cfg_wr) begin
            case (cbt_pkg::cfg_index_t'(paddr[cbt_pkg::CFG_ADDR_W-1 -: 2]))
                cbt_pkg::CFG_CAMERA_X:  cam_reg[0] <= pwdata;
                cbt_pkg::CFG_CAMERA_Y:  cam_reg[1] <= pwdata;
                cbt_pkg::CFG_CAMERA_Z:  cam_reg[2] <= pwdata;
                cbt_pkg::CFG_NEAR_ZERO: nzl_reg    <= pwdata[cbt_pkg::NZL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cbt_pkg::cfg_index_t'(paddr[cbt_pkg::CFG_ADDR_W-1 -: 2]))
            cbt_pkg::CFG_CAMERA_X:  prdata = cam_reg[0];
            cbt_pkg::CFG_CAMERA_Y:  prdata = cam_reg[1];
            cbt_pkg::CFG_CAMERA_Z:  prdata = cam_reg[2];
            cbt_pkg::CFG_NEAR_ZERO: prdata = 32'(nzl_reg);
            default:                prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic [1:0]       count_reg;
    logic [OUT_W-1:0] head_reg;
    logic [OUT_W-1:0] tail_reg;
    logic             pipe_en;
    logic [S_P:1]     vld_reg;
    logic             push;
    logic             pop;
    logic [OUT_W-1:0] out_word;

    assign pipe_en  = (count_reg != 2'd2);
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[S_P-1:1], s_tvalid};
        end
    end

    // ---------------- stage 1: differences ----------------
    logic signed [DIFF_W-1:0] val_next [9];
    logic signed [DIFF_W-1:0] val_reg  [9];
    logic                     degen_next;
    logic                     degen_st1_reg;
    logic [CW-1:0]            radius_st1_reg;
    logic signed [DIFF_W-1:0] p_ext [3];
    logic signed [DIFF_W-1:0] q_ext [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_ext[i]      = DIFF_W'($signed(s_tdata[CW*i +: CW]));
            q_ext[i]      = DIFF_W'($signed(s_tdata[CW*(3+i) +: CW]));
            val_next[i]   = q_ext[i] - p_ext[i];
            val_next[3+i] = p_ext[i] - DIFF_W'(cam_reg[i]);
            val_next[6+i] = q_ext[i] - DIFF_W'(cam_reg[i]);
        end
        degen_next = (s_tdata[3*CW-1:0] == s_tdata[6*CW-1:3*CW]);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 9; i++) begin
                val_reg[i] <= val_next[i];
            end
            degen_st1_reg  <= degen_next;
            radius_st1_reg <= s_tdata[6*CW +: CW];
        end
    end

    // ---------------- stages 2 and 3: squares and sums ----------------
    logic [MAG_W-1:0]  vmag   [9];
    logic [SUM1_W-1:0] sq_reg [9];
    logic [SUM1_W-1:0] sum_reg [3];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            vmag[i] = val_reg[i][DIFF_W-1] ? MAG_W'(-val_reg[i]) : MAG_W'(val_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 9; i++) begin
                sq_reg[i] <= vmag[i] * vmag[i];
            end
            for (int g = 0; g < 3; g++) begin
                sum_reg[g] <= sq_reg[3*g] + sq_reg[3*g+1] + sq_reg[3*g+2];
            end
        end
    end

    // ---------------- length and end point distances ----------------
    logic [LEN_W-1:0] root1 [3];

    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_norm
            cbt_isqrt #(.IN_W(SUM1_W)) u_isqrt (
                .aclk     (aclk),
                .en       (pipe_en),
                .radicand (sum_reg[gi]),
                .root     (root1[gi])
            );
        end
    endgenerate

    logic [3*MAG_W-1:0] dmag_in;
    logic [3*MAG_W-1:0] dmag_l;
    logic [3:0]         dsgn_in;
    logic [3:0]         dsgn_q;

    assign dmag_in = {vmag[2], vmag[1], vmag[0]};
    assign dsgn_in = {degen_st1_reg, val_reg[2][DIFF_W-1], val_reg[1][DIFF_W-1],
                      val_reg[0][DIFF_W-1]};

    cbt_delay #(.W(3*MAG_W), .DEPTH(S_L-1)) u_dly_dmag (
        .aclk(aclk), .en(pipe_en), .din(dmag_in), .dout(dmag_l)
    );
    cbt_delay #(.W(4), .DEPTH(S_Q-1)) u_dly_dsgn (
        .aclk(aclk), .en(pipe_en), .din(dsgn_in), .dout(dsgn_q)
    );

    logic [CW-1:0]    radius_b;
    logic [LEN_W-1:0] len_b;
    logic [LEN_W-1:0] dist_min;
    logic [ND_W-1:0]  nd_in;
    logic [ND_W-1:0]  nd_p;

    cbt_delay #(.W(CW), .DEPTH(S_B-1)) u_dly_radius (
        .aclk(aclk), .en(pipe_en), .din(radius_st1_reg), .dout(radius_b)
    );
    cbt_delay #(.W(LEN_W), .DEPTH(S_B-S_L)) u_dly_len (
        .aclk(aclk), .en(pipe_en), .din(root1[0]), .dout(len_b)
    );

    always_comb begin
        dist_min = (root1[1] < root1[2]) ? root1[1] : root1[2];
        nd_in    = (dist_min > LEN_W'(31'h7fff_ffff)) ? 31'h7fff_ffff : dist_min[ND_W-1:0];
    end

    cbt_delay #(.W(ND_W), .DEPTH(S_P-S_L)) u_dly_nd (
        .aclk(aclk), .en(pipe_en), .din(nd_in), .dout(nd_p)
    );

    // ---------------- unit axis ----------------
    logic [Q_W-1:0] quo1 [3];

    generate
        for (gi = 0; gi < 3; gi++) begin : g_unit
            cbt_udiv #(.NUM_W(NUM1_W), .DEN_W(LEN_W), .QUO_W(Q_W)) u_udiv (
                .aclk (aclk),
                .en   (pipe_en),
                .num  ({dmag_l[MAG_W*gi +: MAG_W], {F{1'b0}}}),
                .den  (root1[0]),
                .quo  (quo1[gi])
            );
        end
    endgenerate

    logic [Q_W-1:0]        umag [3];
    logic [2:0]            usgn;
    logic                  use_x_helper;
    logic [CMAG_W-1:0]     cmag_next [3];
    logic [2:0]            csgn_next;
    logic signed [U_W-1:0] u_next [3];
    logic signed [U_W-1:0] u_reg  [3];
    logic [CMAG_W-1:0]     cmag_reg [3];
    logic [3:0]            csgn_reg;
    logic                  degen_p;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // coinciding end points divide by zero; force the axis to zero
            umag[i]   = dsgn_q[3] ? '0 : quo1[i];
            usgn[i]   = dsgn_q[i];
            u_next[i] = usgn[i] ? -U_W'(umag[i]) : U_W'(umag[i]);
        end
        use_x_helper = (CMP_W'(umag[0]) < CMP_W'(nzl_reg)) &&
                       (CMP_W'(umag[2]) < CMP_W'(nzl_reg));
        if (use_x_helper) begin
            cmag_next[0] = '0;      csgn_next[0] = 1'b0;
            cmag_next[1] = umag[2]; csgn_next[1] = usgn[2];
            cmag_next[2] = umag[1]; csgn_next[2] = ~usgn[1];
        end else begin
            cmag_next[0] = umag[2]; csgn_next[0] = ~usgn[2];
            cmag_next[1] = '0;      csgn_next[1] = 1'b0;
            cmag_next[2] = umag[0]; csgn_next[2] = usgn[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i]    <= u_next[i];
                cmag_reg[i] <= cmag_next[i];
            end
            csgn_reg <= {(cmag_next[0] == '0) && (cmag_next[1] == '0) && (cmag_next[2] == '0),
                         csgn_next};
        end
    end

    cbt_delay #(.W(1), .DEPTH(S_P-S_Q)) u_dly_degen (
        .aclk(aclk), .en(pipe_en), .din(dsgn_q[3]), .dout(degen_p)
    );

    // ---------------- first side ----------------
    logic [CSUM_W-1:0] csq_reg [3];
    logic [CSUM_W-1:0] csum_reg;
    logic [CLEN_W-1:0] clen;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                csq_reg[i] <= cmag_reg[i] * cmag_reg[i];
            end
            // one term is always zero, so the sum keeps its width
            csum_reg <= csq_reg[0] + csq_reg[1] + csq_reg[2];
        end
    end

    cbt_isqrt #(.IN_W(CSUM_W)) u_isqrt_side (
        .aclk(aclk), .en(pipe_en), .radicand(csum_reg), .root(clen)
    );

    logic [3*CMAG_W-1:0] cmag_cl;
    logic [3:0]          csgn_a0;

    cbt_delay #(.W(3*CMAG_W), .DEPTH(S_CL-S_U)) u_dly_cmag (
        .aclk(aclk), .en(pipe_en), .din({cmag_reg[2], cmag_reg[1], cmag_reg[0]}),
        .dout(cmag_cl)
    );
    cbt_delay #(.W(4), .DEPTH(S_A0-S_U)) u_dly_csgn (
        .aclk(aclk), .en(pipe_en), .din(csgn_reg), .dout(csgn_a0)
    );

    logic [Q_W-1:0] quo2 [3];

    generate
        for (gi = 0; gi < 3; gi++) begin : g_side
            cbt_udiv #(.NUM_W(NUM2_W), .DEN_W(CLEN_W), .QUO_W(Q_W)) u_udiv (
                .aclk (aclk),
                .en   (pipe_en),
                .num  ({cmag_cl[CMAG_W*gi +: CMAG_W], {F{1'b0}}}),
                .den  (clen),
                .quo  (quo2[gi])
            );
        end
    endgenerate

    logic signed [A_W-1:0] a_reg [3];
    logic [3*U_W-1:0]      u_a_vec;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                // a vanishing cross gives zero sides
                if (csgn_a0[3]) begin
                    a_reg[i] <= '0;
                end else begin
                    a_reg[i] <= csgn_a0[i] ? -A_W'(quo2[i]) : A_W'(quo2[i]);
                end
            end
        end
    end

    cbt_delay #(.W(3*U_W), .DEPTH(S_A-S_U)) u_dly_u_a (
        .aclk(aclk), .en(pipe_en), .din({u_reg[2], u_reg[1], u_reg[0]}), .dout(u_a_vec)
    );

    // ---------------- second side ----------------
    logic signed [U_W-1:0]  ua_u [3];
    logic signed [UA_W-1:0] ua_reg [6];
    logic signed [BD_W-1:0] bdiff [3];
    logic [BD_W-1:0]        bmag [3];
    logic [BD_W-1:0]        bshift [3];
    logic signed [B_W-1:0]  b_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ua_u[i] = $signed(u_a_vec[U_W*i +: U_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ua_reg[0] <= UA_W'(ua_u[1]) * UA_W'(a_reg[2]);
            ua_reg[1] <= UA_W'(ua_u[2]) * UA_W'(a_reg[1]);
            ua_reg[2] <= UA_W'(ua_u[2]) * UA_W'(a_reg[0]);
            ua_reg[3] <= UA_W'(ua_u[0]) * UA_W'(a_reg[2]);
            ua_reg[4] <= UA_W'(ua_u[0]) * UA_W'(a_reg[1]);
            ua_reg[5] <= UA_W'(ua_u[1]) * UA_W'(a_reg[0]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bdiff[i]  = BD_W'(ua_reg[2*i]) - BD_W'(ua_reg[2*i+1]);
            bmag[i]   = bdiff[i][BD_W-1] ? BD_W'(-bdiff[i]) : BD_W'(bdiff[i]);
            bshift[i] = bmag[i] >> F;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                b_reg[i] <= bdiff[i][BD_W-1] ? -B_W'(bshift[i]) : B_W'(bshift[i]);
            end
        end
    end

    logic [3*U_W-1:0] u_b_vec;
    logic [3*A_W-1:0] a_b_vec;

    cbt_delay #(.W(3*U_W), .DEPTH(S_B-S_A)) u_dly_u_b (
        .aclk(aclk), .en(pipe_en), .din(u_a_vec), .dout(u_b_vec)
    );
    cbt_delay #(.W(3*A_W), .DEPTH(S_B-S_A)) u_dly_a_b (
        .aclk(aclk), .en(pipe_en), .din({a_reg[2], a_reg[1], a_reg[0]}), .dout(a_b_vec)
    );

    // ---------------- scaled outputs ----------------
    logic signed [P_W-1:0] prod_reg [9];
    logic                  caps_reg;
    logic signed [P_W-1:0] rad_ext;
    logic signed [P_W-1:0] len_ext;

    assign rad_ext = P_W'($signed(radius_b));
    assign len_ext = P_W'($signed({1'b0, len_b}));

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i]   <= rad_ext * P_W'($signed(a_b_vec[A_W*i +: A_W]));
                prod_reg[3+i] <= len_ext * P_W'($signed(u_b_vec[U_W*i +: U_W]));
                prod_reg[6+i] <= rad_ext * P_W'(b_reg[i]);
            end
            caps_reg <= !radius_b[CW-1] && (radius_b != '0);
        end
    end

    always_comb begin
        out_word = '0;
        for (int i = 0; i < 9; i++) begin
            out_word[CW*i +: CW] = sat_scale(prod_reg[i]);
        end
        out_word[9*CW +: ND_W] = nd_p;
        out_word[cbt_pkg::M_TDATA_W + cbt_pkg::TUSER_CAPS]  = caps_reg;
        out_word[cbt_pkg::M_TDATA_W + cbt_pkg::TUSER_DEGEN] = degen_p;
    end

    // ---------------- output buffer ----------------
    assign push = pipe_en && vld_reg[S_P];
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            case (count_reg)
                2'd0: if (push) count_reg <= 2'd1;
                2'd1: begin
                    if (push && !pop) count_reg <= 2'd2;
                    else if (!push && pop) count_reg <= 2'd0;
                end
                2'd2: if (pop) count_reg <= 2'd1;
                default: count_reg <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (count_reg == 2'd2) begin
            if (pop) head_reg <= tail_reg;
        end else if (push) begin
            if (count_reg == 2'd0 || pop) head_reg <= out_word;
            else tail_reg <= out_word;
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = head_reg[cbt_pkg::M_TDATA_W-1:0];
    assign m_tuser  = head_reg[OUT_W-1 -: cbt_pkg::M_TUSER_W];

endmodule

### rtl/cbt_checker.sv
// port-level checks of the cylinder basis transform unit and their binding
`include "cylinder_basis_transform_unit_macros.svh"

module cbt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cbt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [cbt_pkg::M_TUSER_W-1:0] m_tuser
);
    // zero vectors on coinciding end points
    `CBT_ASSERT_NOW(a_degen_zero, aclk, aresetn, m_tvalid && m_tuser[cbt_pkg::TUSER_DEGEN], m_tdata[cbt_pkg::VEC_FIELDS_W-1:0] == '0, "degenerate result with nonzero vectors")

    // an empty output buffer never holds off the input side
    `CBT_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready, "input stalled with no result waiting")

    // reset empties the output
    `CBT_ASSERT_ALWAYS(a_reset_empty, aclk, $past(!aresetn), !m_tvalid, "result shown right after reset")

    `CBT_ASSERT_NEXT(a_valid_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule

bind cylinder_basis_transform_unit cbt_checker u_cbt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/cylinder_basis_transform_unit_tb.sv
// self-checking stream testbench of the cylinder basis transform unit
module cylinder_basis_transform_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int LATENCY = 3 * FRAC + 46;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD = 300;
    localparam int ND_LSB = 9 * cbt_pkg::COORD_W;
    localparam int ND_W = cbt_pkg::NEAR_DIST_W;

    typedef logic signed [cbt_pkg::COORD_W-1:0] coord_t;

    typedef struct {
        coord_t pa[3];
        coord_t pb[3];
        coord_t radius;
    } segment_t;

    typedef struct {
        logic [cbt_pkg::M_TDATA_W-1:0] data;
        logic [cbt_pkg::M_TUSER_W-1:0] user;
    } basis_t;

    typedef struct {
        segment_t seg;
        bit       typed;
        basis_t   want;
    } row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic [cbt_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [cbt_pkg::M_TDATA_W-1:0] m_tdata;
    logic [cbt_pkg::M_TUSER_W-1:0] m_tuser;
    logic m_tvalid;
    logic m_tready = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [cbt_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [cbt_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [cbt_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    // shadow of the configuration registers
    coord_t cam[3];
    logic [cbt_pkg::NZL_W-1:0] nzl;

    basis_t basis_q[$];
    row_t directed_q[$];
    int errors = 0;
    int stall_cycles = 0;
    bit quiet = 0;
    bit long_hold_req = 0;

    cylinder_basis_transform_unit #(.FRAC_BITS(FRAC)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 aclk = ~aclk;

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint signed_mag(longint unsigned m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint shift_down(longint v);
        return signed_mag(mag(v) >> FRAC, v < 0);
    endfunction

    function automatic longint to_unit(longint num, longint unsigned den);
        return signed_mag((mag(num) << FRAC) / den, num < 0);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor of the root of a 66 bit sum of three squares, bit pair by bit pair
    function automatic longint unsigned vec_length(longint a, longint b, longint c);
        logic [65:0] sum;
        logic [69:0] rem, root, trial;
        sum = {2'b0, mag(a) * mag(a)} + {2'b0, mag(b) * mag(b)} + {2'b0, mag(c) * mag(c)};
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | ((sum >> (2 * i)) & 66'd3);
            trial = (root << 2) | 70'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 70'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[63:0];
    endfunction

    function automatic basis_t predict_basis(segment_t s);
        longint d[3], u[3], c[3], a[3], b[3], res[9], rad;
        longint unsigned len, clen, d1, d2, nd;
        bit degen;
        basis_t r;
        rad = s.radius;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(s.pb[i]) - longint'(s.pa[i]);
            u[i] = 0; c[i] = 0; a[i] = 0; b[i] = 0;
        end
        len = vec_length(d[0], d[1], d[2]);
        degen = (d[0] == 0 && d[1] == 0 && d[2] == 0);
        if (!degen) begin
            for (int i = 0; i < 3; i++) u[i] = to_unit(d[i], len);
            if (mag(u[0]) < longint'(nzl) && mag(u[2]) < longint'(nzl)) begin
                c[0] = 0; c[1] = u[2]; c[2] = -u[1];
            end else begin
                c[0] = -u[2]; c[1] = 0; c[2] = u[0];
            end
            clen = vec_length(c[0], c[1], c[2]);
            // axis along y with a zero limit leaves no side vectors
            if (clen != 0) begin
                for (int i = 0; i < 3; i++) a[i] = to_unit(c[i], clen);
                b[0] = shift_down(u[1] * a[2] - u[2] * a[1]);
                b[1] = shift_down(u[2] * a[0] - u[0] * a[2]);
                b[2] = shift_down(u[0] * a[1] - u[1] * a[0]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            res[i] = clamp32(shift_down(rad * a[i]));
            res[3 + i] = degen ? 0 : clamp32(shift_down(longint'(len) * u[i]));
            res[6 + i] = clamp32(shift_down(rad * b[i]));
        end
        d1 = vec_length(longint'(s.pa[0]) - cam[0], longint'(s.pa[1]) - cam[1],
                        longint'(s.pa[2]) - cam[2]);
        d2 = vec_length(longint'(s.pb[0]) - cam[0], longint'(s.pb[1]) - cam[1],
                        longint'(s.pb[2]) - cam[2]);
        nd = d1 < d2 ? d1 : d2;
        if (nd > 64'h7FFF_FFFF) nd = 64'h7FFF_FFFF;
        r.data = '0;
        for (int i = 0; i < 9; i++) r.data[32 * i +: 32] = res[i][31:0];
        r.data[ND_LSB +: ND_W] = nd[ND_W-1:0];
        r.user = '0;
        r.user[cbt_pkg::TUSER_CAPS] = rad > 0;
        r.user[cbt_pkg::TUSER_DEGEN] = degen;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker and stall watchdog
    always @(posedge aclk) begin
        basis_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("cylinder_basis_transform_unit_tb NOT OK");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (basis_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[31:0], '0);
                end else begin
                    want = basis_q.pop_front();
                    for (int f = 0; f < 9; f++) begin
                        if (m_tdata[32 * f +: 32] !== want.data[32 * f +: 32])
                            report_mismatch($sformatf("vector field %0d", f),
                                            m_tdata[32 * f +: 32], want.data[32 * f +: 32]);
                    end
                    if (m_tdata[ND_LSB +: ND_W] !== want.data[ND_LSB +: ND_W])
                        report_mismatch("near_distance", {1'b0, m_tdata[ND_LSB +: ND_W]},
                                        {1'b0, want.data[ND_LSB +: ND_W]});
                    if (m_tdata[cbt_pkg::M_TDATA_W-1] !== 1'b0)
                        report_mismatch("pad bit", {31'b0, m_tdata[cbt_pkg::M_TDATA_W-1]}, '0);
                    if (m_tuser[cbt_pkg::TUSER_CAPS] !== want.user[cbt_pkg::TUSER_CAPS])
                        report_mismatch("caps_enabled", {31'b0, m_tuser[cbt_pkg::TUSER_CAPS]},
                                        {31'b0, want.user[cbt_pkg::TUSER_CAPS]});
                    if (m_tuser[cbt_pkg::TUSER_DEGEN] !== want.user[cbt_pkg::TUSER_DEGEN])
                        report_mismatch("degenerate", {31'b0, m_tuser[cbt_pkg::TUSER_DEGEN]},
                                        {31'b0, want.user[cbt_pkg::TUSER_DEGEN]});
                end
            end
        end
    end

    // receiver: random back-pressure bursts and one long hold-off
    initial begin
        @(posedge aresetn);
        @(posedge aclk);
        m_tready <= 1;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 0;
                m_tready <= 0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_tready <= 1;
            end
        end
    end

    task automatic send_segment(segment_t s, basis_t want);
        s_tdata <= {s.radius, s.pb[2], s.pb[1], s.pb[0], s.pa[2], s.pa[1], s.pa[0]};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        basis_q.insert(basis_q.size(), want);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (basis_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic cfg_write(cbt_pkg::cfg_index_t idx, logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= cbt_pkg::CFG_ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            cbt_pkg::CFG_CAMERA_X:  cam[0] = value;
            cbt_pkg::CFG_CAMERA_Y:  cam[1] = value;
            cbt_pkg::CFG_CAMERA_Z:  cam[2] = value;
            cbt_pkg::CFG_NEAR_ZERO: nzl = value[cbt_pkg::NZL_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_camera_limit(coord_t x, coord_t y, coord_t z,
                                    logic [cbt_pkg::NZL_W-1:0] lim);
        wait_drained();
        cfg_write(cbt_pkg::CFG_CAMERA_X, x);
        cfg_write(cbt_pkg::CFG_CAMERA_Y, y);
        cfg_write(cbt_pkg::CFG_CAMERA_Z, z);
        cfg_write(cbt_pkg::CFG_NEAR_ZERO, {15'b0, lim});
    endtask

    function automatic segment_t make_segment(coord_t ax, coord_t ay, coord_t az,
                                              coord_t bx, coord_t by, coord_t bz, coord_t r);
        segment_t s;
        s.pa[0] = ax; s.pa[1] = ay; s.pa[2] = az;
        s.pb[0] = bx; s.pb[1] = by; s.pb[2] = bz;
        s.radius = r;
        return s;
    endfunction

    task automatic add_row(segment_t s, bit typed, logic [cbt_pkg::M_TDATA_W-1:0] data,
                           logic [cbt_pkg::M_TUSER_W-1:0] user);
        row_t r;
        r.seg = s;
        r.typed = typed;
        r.want.data = data;
        r.want.user = user;
        directed_q.insert(directed_q.size(), r);
    endtask

    function automatic coord_t rand_coord(int kind);
        case (kind)
            0: return coord_t'($urandom());
            1: return coord_t'(int'($urandom_range(0, 2 * 1048576)) - 1048576);
            default: return coord_t'(int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic segment_t rand_segment();
        segment_t s;
        int mode, kind;
        mode = $urandom_range(0, 19);
        kind = $urandom_range(0, 1);
        for (int i = 0; i < 3; i++) begin
            s.pa[i] = rand_coord(kind);
            s.pb[i] = rand_coord(kind);
        end
        if (mode == 0) begin
            s.pb = s.pa;
        end else if (mode < 6) begin
            // nearly along y so both helper choices are exercised
            s.pb[0] = s.pa[0] + rand_coord(2);
            s.pb[2] = s.pa[2] + rand_coord(2);
        end
        case ($urandom_range(0, 3))
            0: s.radius = coord_t'($urandom());
            1: s.radius = coord_t'(int'($urandom_range(0, 4 * 65536)) - 2 * 65536);
            2: s.radius = coord_t'(int'($urandom_range(0, 4)) - 2);
            default: s.radius = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
        return s;
    endfunction

    task automatic run_random(int count, bit with_hold);
        segment_t s;
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == 10) long_hold_req = 1;
            s = rand_segment();
            send_segment(s, predict_basis(s));
            if (!(with_hold && n >= 10 && n < 250)) sender_gap();
        end
    endtask

    localparam coord_t CMAX = 32'sh7FFF_FFFF;
    localparam coord_t CMIN = 32'sh8000_0000;
    localparam coord_t ONE  = 32'sh0001_0000;

    initial begin
        segment_t s;
        logic [cbt_pkg::M_TDATA_W-1:0] unit_x;
        cam[0] = 0; cam[1] = 0; cam[2] = 0;
        nzl = cbt_pkg::NZL_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // unit x axis: side a along z, side b along minus y
        unit_x = '0;
        unit_x[2 * 32 +: 32] = ONE;
        unit_x[3 * 32 +: 32] = ONE;
        unit_x[7 * 32 +: 32] = -ONE;
        add_row(make_segment(0, 0, 0, 0, 0, 0, 1), 1, '0, 2'b11);
        add_row(make_segment(0, 0, 0, ONE, 0, 0, ONE), 1, unit_x, 2'b01);
        add_row(make_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX), 0, '0, '0);
        add_row(make_segment(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN), 0, '0, '0);
        add_row(make_segment(CMAX, CMIN, 0, CMIN, CMAX, 0, CMAX), 0, '0, '0);
        add_row(make_segment(0, 0, 0, 0, 0, ONE, 0), 0, '0, '0);
        add_row(make_segment(0, 0, 0, 0, ONE, 0, -1), 0, '0, '0);
        add_row(make_segment(0, 0, 0, 0, 0, 1, ONE), 0, '0, '0);
        add_row(make_segment(5, 5, 5, 5, 5, 5, -ONE), 0, '0, '0);
        add_row(make_segment(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN), 0, '0, '0);
        add_row(make_segment(0, 0, 0, 1, 100000, 0, ONE), 0, '0, '0);
        add_row(make_segment(CMIN, 0, CMIN, CMAX, 0, CMAX, CMAX), 0, '0, '0);
        add_row(make_segment(-3, 7, 11, 1000, -2000, 300, 1), 0, '0, '0);
        foreach (directed_q[i]) begin
            send_segment(directed_q[i].seg,
                         directed_q[i].typed ? directed_q[i].want : predict_basis(directed_q[i].seg));
        end

        // zero limit: axis along y has no side vectors
        set_camera_limit(CMAX, CMIN, CMAX, '0);
        s = make_segment(0, 0, 0, 0, ONE, 0, ONE);
        send_segment(s, predict_basis(s));
        s = make_segment(0, CMAX, 0, 0, CMIN, 0, CMAX);
        send_segment(s, predict_basis(s));
        run_random(200, 0);

        set_camera_limit(CMIN, CMIN, CMIN, 17'd65536);
        run_random(200, 1);
        set_camera_limit(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
                         17'h1FFFF);
        run_random(200, 0);
        set_camera_limit(0, 0, 0, 17'd1);
        run_random(200, 0);
        set_camera_limit(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
                         cbt_pkg::NZL_W'($urandom()));
        run_random(200, 0);
        quiet = 1;
        run_random(200, 0);

        wait_drained();
        repeat (LATENCY + 20) @(posedge aclk);
        if (errors == 0) begin
            $display("cylinder_basis_transform_unit_tb OK");
        end else begin
            $display("cylinder_basis_transform_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

### cylinder_basis_transform_unit.f
+incdir+rtl
rtl/cbt_pkg.sv
rtl/cbt_isqrt.sv
rtl/cbt_udiv.sv
rtl/cbt_delay.sv
rtl/cylinder_basis_transform_unit.sv
rtl/cbt_checker.sv
verif/cylinder_basis_transform_unit_tb.sv
